// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file ncg_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define NCG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define NCG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `NCG_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- src/ncg_pkg.sv -----
// ----------------------------------------------------------------------------
// ncg_pkg
// Types and constants of the next-combination generator.
// ----------------------------------------------------------------------------
package ncg_pkg;

    localparam int SET_SIZE_W  = 9;
    localparam int COMB_SIZE_W = 5;
    localparam int CFG_DATA_W  = 9;
    localparam int POS_W       = 4;
    localparam int ELEM_W      = 8;
    localparam int LIMIT_W     = SET_SIZE_W + 1;

    typedef logic [0:0]            t_cfg_addr;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [ELEM_W-1:0]     t_elem;
    typedef logic [POS_W-1:0]      t_pos;

    localparam t_cfg_addr CFG_SET_SIZE  = 1'b0;
    localparam t_cfg_addr CFG_COMB_SIZE = 1'b1;

    localparam logic [SET_SIZE_W-1:0]  SET_SIZE_RST  = 9'd8;
    localparam logic [COMB_SIZE_W-1:0] COMB_SIZE_RST = 5'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_ADV,
        S_BAD
    } t_state;

endpackage

// ----- src/ncg_store.sv -----
// ----------------------------------------------------------------------------
// ncg_store
// Slot store: one write port, one registered read port that holds its data
// while not enabled. Per-slot valid flags make an unwritten slot read as its
// own index; a restart drops the flags of the slots below k.
// ----------------------------------------------------------------------------
module ncg_store #(
    parameter int MAX_K = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_we,
    input  logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0] i_waddr,
    input  ncg_pkg::t_elem                               i_wdata,
    input  logic                                         i_re,
    input  logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0] i_raddr,
    input  logic                                         i_clr,
    input  logic [$clog2(MAX_K + 1)-1:0]                 i_clr_k,
    output ncg_pkg::t_elem                               o_rdata
);
    import ncg_pkg::*;

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    t_elem             r_mem [MAX_K];
    logic [MAX_K-1:0]  r_vld;
    t_elem             r_rdata;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int j = 0; j < MAX_K; j++) begin
                if (i_clr && (j < int'(i_clr_k))) begin
                    r_vld[j] <= 1'b0;
                end
            end
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata   <= r_mem[i_raddr];
            r_rd_vld  <= r_vld[i_raddr];
            r_rd_addr <= i_raddr;
        end
    end

    // unwritten slot i reads as i
    assign o_rdata = r_rd_vld ? r_rdata : ELEM_W'(r_rd_addr);

endmodule

// ----- src/next_combination_generator_core.sv -----
// Per item: a scan pass that reads slots 0..k-1 and finds the pivot, an emit
// pass (one read step, k results at one per cycle while the output is not
// stalled, one closing step), then rewrites of slots p..k-1 (p = pivot, none
// on the last combination). A bad setting (k > n) gives one error result. A
// new item is taken only once the last is through. Both passes use the single
// slot-store read port. Reset: n=8, k=3, slot i reads i, idle.
// ----------------------------------------------------------------------------
// next_combination_generator_core
// Steps a k-combination of 0..n-1 through lexicographic order, one
// combination per input item, with a sequencer around one limit comparator.
// ----------------------------------------------------------------------------
module next_combination_generator_core #(
    parameter int MAX_K = 16,
    parameter int MAX_N = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  ncg_pkg::t_cfg_addr    i_cfg_addr,
    input  ncg_pkg::t_cfg_data    i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_restart,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ncg_pkg::t_pos         o_position,
    output ncg_pkg::t_elem        o_element_index,
    output logic                  o_last_of_run,
    output logic                  o_final_combination,
    output logic                  o_bad_setting
);
    import ncg_pkg::*;

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KW = $clog2(MAX_K + 1);

    t_state                  r_state, n_state;
    logic [SET_SIZE_W-1:0]   r_set_size;
    logic [COMB_SIZE_W-1:0]  r_comb_size;
    logic [SET_SIZE_W-1:0]   r_n, n_n;
    logic [KW-1:0]           r_k, n_k;
    logic [KW-1:0]           r_ra, n_ra;
    logic                    r_cmp_vld, n_cmp_vld;
    logic [KW-1:0]           r_cmp_pos, n_cmp_pos;
    logic                    r_piv_found, n_piv_found;
    logic [KW-1:0]           r_piv, n_piv;
    t_elem                   r_piv_val, n_piv_val;
    logic [KW-1:0]           r_wa, n_wa;
    t_elem                   r_wd, n_wd;

    logic [SET_SIZE_W-1:0]   eff_n;
    logic [KW-1:0]           eff_k;
    logic                    in_fire;
    logic                    below_limit;
    logic [LIMIT_W-1:0]      limit;
    logic                    st_we, st_re, st_clr;
    t_elem                   st_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size  <= SET_SIZE_RST;
            r_comb_size <= COMB_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SET_SIZE:  r_set_size  <= i_cfg_wdata[SET_SIZE_W-1:0];
                CFG_COMB_SIZE: r_comb_size <= i_cfg_wdata[COMB_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate n into 1..MAX_N and k into 1..MAX_K
    always_comb begin
        if (r_set_size == '0) begin
            eff_n = SET_SIZE_W'(1);
        end else if (int'(r_set_size) > MAX_N) begin
            eff_n = SET_SIZE_W'(MAX_N);
        end else begin
            eff_n = r_set_size;
        end
        if (r_comb_size == '0) begin
            eff_k = KW'(1);
        end else if (int'(r_comb_size) > MAX_K) begin
            eff_k = KW'(MAX_K);
        end else begin
            eff_k = KW'(r_comb_size);
        end
    end

    assign in_fire = i_in_valid && o_in_ready;

    // limit comparator: slot value below n-k+pos
    assign limit       = LIMIT_W'(r_n) - LIMIT_W'(r_k) + LIMIT_W'(r_cmp_pos);
    assign below_limit = LIMIT_W'(st_rdata) < limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_piv_found <= 1'b0;
            r_ra        <= '0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_piv_found <= n_piv_found;
            r_ra        <= n_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_k       <= n_k;
        r_cmp_pos <= n_cmp_pos;
        r_piv     <= n_piv;
        r_piv_val <= n_piv_val;
        r_wa      <= n_wa;
        r_wd      <= n_wd;
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_k         = r_k;
        n_ra        = r_ra;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_pos   = r_cmp_pos;
        n_piv_found = r_piv_found;
        n_piv       = r_piv;
        n_piv_val   = r_piv_val;
        n_wa        = r_wa;
        n_wd        = r_wd;
        st_we       = 1'b0;
        st_re       = 1'b0;
        st_clr      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_n         = eff_n;
                    n_k         = eff_k;
                    st_clr      = i_restart;
                    n_ra        = '0;
                    n_cmp_vld   = 1'b0;
                    n_piv_found = 1'b0;
                    n_state     = (int'(eff_k) > int'(eff_n)) ? S_BAD : S_SCAN;
                end
            end
            S_SCAN: begin
                // forward pass; the last slot below its limit is the pivot
                if (r_ra < r_k) begin
                    st_re     = 1'b1;
                    n_ra      = r_ra + KW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_pos = r_ra;
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld && below_limit) begin
                    n_piv_found = 1'b1;
                    n_piv       = r_cmp_pos;
                    n_piv_val   = st_rdata;
                end
                if ((r_ra == r_k) && !r_cmp_vld) begin
                    n_ra    = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_cmp_vld || i_out_ready) begin
                    if (r_ra < r_k) begin
                        st_re     = 1'b1;
                        n_ra      = r_ra + KW'(1);
                        n_cmp_vld = 1'b1;
                        n_cmp_pos = r_ra;
                    end else begin
                        n_cmp_vld = 1'b0;
                    end
                end
                if ((r_ra == r_k) && !r_cmp_vld) begin
                    n_wa    = r_piv;
                    n_wd    = r_piv_val + ELEM_W'(1);
                    n_state = r_piv_found ? S_ADV : S_IDLE;
                end
            end
            S_ADV: begin
                // pivot gets +1, later slots follow consecutively
                st_we = 1'b1;
                n_wa  = r_wa + KW'(1);
                n_wd  = r_wd + ELEM_W'(1);
                if (r_wa == r_k - KW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_BAD: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    ncg_store #(
        .MAX_K (MAX_K)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (r_wa[AW-1:0]),
        .i_wdata (r_wd),
        .i_re    (st_re),
        .i_raddr (r_ra[AW-1:0]),
        .i_clr   (st_clr),
        .i_clr_k (eff_k),
        .o_rdata (st_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = ((r_state == S_EMIT) && r_cmp_vld) || (r_state == S_BAD);

    always_comb begin
        if (r_state == S_BAD) begin
            o_position          = '0;
            o_element_index     = '0;
            o_last_of_run       = 1'b1;
            o_final_combination = 1'b0;
            o_bad_setting       = 1'b1;
        end else begin
            o_position          = POS_W'(r_cmp_pos);
            o_element_index     = st_rdata;
            o_last_of_run       = (r_cmp_pos == r_k - KW'(1));
            o_final_combination = !r_piv_found;
            o_bad_setting       = 1'b0;
        end
    end

endmodule

// ----- src/ncg_checker.sv -----
// ----------------------------------------------------------------------------
// ncg_checker
// Port-level checks of the next-combination generator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ncg_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  ncg_pkg::t_pos         i_position,
    input  ncg_pkg::t_elem        i_element_index,
    input  logic                  i_last_of_run,
    input  logic                  i_final_combination,
    input  logic                  i_bad_setting
);
    import ncg_pkg::*;

    // a stalled result keeps its slot and value
    `NCG_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_position) && $stable(i_element_index)), "result changed while stalled")

    // one item at a time: busy right after an accept
    `NCG_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "item accepted while busy")

    // results only come out while an item is in work
    `NCG_ASSERT_NEVER(a_no_out_when_idle, i_clk, i_rst_n, i_out_valid && i_in_ready, "result shown while idle")

    // error result is a closing, zeroed, non-final result
    `NCG_ASSERT(a_bad_shape, i_clk, i_rst_n, (i_out_valid && i_bad_setting) |-> (i_last_of_run && !i_final_combination && (i_position == '0) && (i_element_index == '0)), "malformed error result")

endmodule

bind next_combination_generator_core ncg_checker u_ncg_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .i_in_ready          (o_in_ready),
    .i_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .i_position          (o_position),
    .i_element_index     (o_element_index),
    .i_last_of_run       (o_last_of_run),
    .i_final_combination (o_final_combination),
    .i_bad_setting       (o_bad_setting)
);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks next_combination_generator_core. A model of the slot store
// predicts the results of every accepted item, and each result is compared
// in order. Stimulus is directed corner cases, then random phases of
// settings and restart items, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ncg_pkg::*;

    localparam int SLOTS       = 16;
    localparam int ELEMS       = 256;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 60;

    typedef struct packed {
        t_pos  position;
        t_elem element_index;
        logic  last_of_run;
        logic  final_combination;
        logic  bad_setting;
    } t_slot_result;

    class combination_tracker;
        t_elem                   slots[SLOTS];
        logic [SET_SIZE_W-1:0]   set_size;
        logic [COMB_SIZE_W-1:0]  comb_size;
        t_slot_result            expected_slots[$];
        int                      errors;

        function new();
            for (int i = 0; i < SLOTS; i++) slots[i] = t_elem'(i);
            set_size  = SET_SIZE_RST;
            comb_size = COMB_SIZE_RST;
            errors    = 0;
        endfunction

        function void note_write(t_cfg_addr addr, t_cfg_data data);
            if (addr == CFG_SET_SIZE) set_size = data;
            else comb_size = data[COMB_SIZE_W-1:0];
        endfunction

        // Works out the results of one item, then steps to the successor.
        function void note_request(logic restart);
            int n;
            int k;
            int pivot;
            int base;
            t_slot_result r;
            n = (set_size == 0) ? 1 : ((set_size > ELEMS) ? ELEMS : int'(set_size));
            k = (comb_size == 0) ? 1 : ((comb_size > SLOTS) ? SLOTS : int'(comb_size));
            if (restart) begin
                for (int i = 0; i < k; i++) slots[i] = t_elem'(i);
            end
            if (k > n) begin
                r = '0;
                r.last_of_run = 1'b1;
                r.bad_setting = 1'b1;
                expected_slots.push_back(r);
                return;
            end
            // rightmost slot still below its maximum; slots left over from
            // another setting may sit above it and count as maxed
            pivot = -1;
            for (int p = k - 1; p >= 0; p--) begin
                if (int'(slots[p]) < n - k + p) begin
                    pivot = p;
                    break;
                end
            end
            for (int i = 0; i < k; i++) begin
                r.position          = t_pos'(i);
                r.element_index     = slots[i];
                r.last_of_run       = (i == k - 1);
                r.final_combination = (pivot < 0);
                r.bad_setting       = 1'b0;
                expected_slots.push_back(r);
            end
            if (pivot >= 0) begin
                base = int'(slots[pivot]) + 1;
                for (int i = pivot; i < k; i++) slots[i] = t_elem'(base + i - pivot);
            end
        endfunction

        function void check_slot(t_slot_result got);
            t_slot_result want;
            if (expected_slots.size() == 0) begin
                $display("%0t: unexpected result pos=%0d elem=%0d last=%0b fin=%0b bad=%0b",
                         $time, got.position, got.element_index, got.last_of_run,
                         got.final_combination, got.bad_setting);
                errors++;
                return;
            end
            want = expected_slots.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected pos=%0d elem=%0d last=%0b fin=%0b bad=%0b",
                         $time, want.position, want.element_index, want.last_of_run,
                         want.final_combination, want.bad_setting);
                $display("%0t:          actual   pos=%0d elem=%0d last=%0b fin=%0b bad=%0b",
                         $time, got.position, got.element_index, got.last_of_run,
                         got.final_combination, got.bad_setting);
                errors++;
            end
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    t_cfg_addr  cfg_addr   = CFG_SET_SIZE;
    t_cfg_data  cfg_wdata  = '0;
    logic       in_valid   = 1'b0;
    logic       in_restart = 1'b0;
    logic       out_ready  = 1'b0;
    bit         quiet      = 1'b0;
    int         cycles     = 0;

    logic       o_in_ready;
    logic       o_out_valid;
    t_pos       o_position;
    t_elem      o_element_index;
    logic       o_last_of_run;
    logic       o_final_combination;
    logic       o_bad_setting;

    combination_tracker tracker = new();

    next_combination_generator_core #(
        .MAX_K (SLOTS),
        .MAX_N (ELEMS)
    ) dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_addr          (cfg_addr),
        .i_cfg_wdata         (cfg_wdata),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_restart           (in_restart),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (out_ready),
        .o_position          (o_position),
        .o_element_index     (o_element_index),
        .o_last_of_run       (o_last_of_run),
        .o_final_combination (o_final_combination),
        .o_bad_setting       (o_bad_setting)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, tracker.pending());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result side: check what was accepted, then pick the next ready
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            tracker.check_slot(t_slot_result'{o_position, o_element_index, o_last_of_run,
                                              o_final_combination, o_bad_setting});
        end
        out_ready <= quiet || ($urandom_range(99) >= 9);
    end

    // valid stays high from one item to the next unless a gap is taken
    task automatic send_item(input logic restart);
        while (!quiet && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_restart <= restart;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        tracker.note_request(restart);
    endtask

    // hold off until every result is back and the advance has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(input bit do_n, input int unsigned n,
                              input bit do_k, input int unsigned k);
        if (do_n) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_SET_SIZE;
            cfg_wdata <= t_cfg_data'(n);
            @(posedge clk);
            tracker.note_write(CFG_SET_SIZE, t_cfg_data'(n));
        end
        if (do_k) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_COMB_SIZE;
            cfg_wdata <= t_cfg_data'(k);
            @(posedge clk);
            tracker.note_write(CFG_COMB_SIZE, t_cfg_data'(k));
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned n;
        int unsigned k;
        int unsigned kind;
        int unsigned count;
        int          random_items;
        bit          keep_state;
        bit          do_n;
        logic        restart;

        random_items = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting, continuing from the reset slots, then a restart
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        wait_drained();

        // 2 of 4: walk to the last combination and stay there
        write_regs(1'b1, 4, 1'b1, 2);
        send_item(1'b1);
        repeat (6) send_item(1'b0);
        wait_drained();

        // k above n
        write_regs(1'b1, 3, 1'b1, 5);
        send_item(1'b1);
        send_item(1'b0);
        wait_drained();

        // zero registers act as one
        write_regs(1'b1, 0, 1'b1, 0);
        send_item(1'b1);
        send_item(1'b0);
        wait_drained();

        // registers above range saturate to the largest setting
        write_regs(1'b1, 511, 1'b1, 31);
        send_item(1'b1);
        send_item(1'b0);
        wait_drained();
        write_regs(1'b1, ELEMS, 1'b1, SLOTS);
        send_item(1'b0);
        wait_drained();

        // settings changed mid-run keep the slots
        write_regs(1'b0, 0, 1'b1, 1);
        send_item(1'b0);
        send_item(1'b0);
        wait_drained();
        write_regs(1'b1, 2, 1'b1, 2);
        send_item(1'b0);
        wait_drained();

        while (random_items < 280) begin
            kind       = $urandom_range(99);
            keep_state = 1'b0;
            count      = $urandom_range(4, 20);
            if (kind < 55) begin
                n = $urandom_range(2, 10);
                k = $urandom_range(1, n);
                write_regs(1'b1, n, 1'b1, k);
            end else if (kind < 67) begin
                n = $urandom_range(1, 8);
                k = $urandom_range(n + 1, 31);
                write_regs(1'b1, n, 1'b1, k);
            end else if (kind < 80) begin
                keep_state = 1'b1;
                do_n       = $urandom_range(1);
                n          = $urandom_range(2, 12);
                k          = $urandom_range(1, 6);
                write_regs(do_n, n, !do_n, k);
            end else if (kind < 90) begin
                n = $urandom_range(1) ? 0 : $urandom_range(257, 511);
                k = $urandom_range(1) ? 0 : $urandom_range(17, 31);
                write_regs(1'b1, n, 1'b1, k);
            end else begin
                n     = $urandom_range(100, ELEMS);
                k     = $urandom_range(10, SLOTS);
                count = $urandom_range(2, 5);
                write_regs(1'b1, n, 1'b1, k);
            end
            for (int j = 0; j < count; j++) begin
                if (j == 0 && !keep_state) restart = ($urandom_range(99) < 70);
                else restart = ($urandom_range(99) < 5);
                send_item(restart);
                random_items++;
                quiet = (random_items >= 100 && random_items < 160);
                if ($urandom_range(99) < 4) wait_drained();
            end
            wait_drained();
        end

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
